// ===== hw/rtl/tbb_pkg.sv =====
// shared types, codes and saturation helper for the text bounding box unit
package tbb_pkg;

   localparam int GLYPH_COUNT_DEFAULT = 128;

   localparam logic [1:0] CMD_LOAD   = 2'd0;
   localparam logic [1:0] CMD_CHAR   = 2'd1;
   localparam logic [1:0] CMD_FINISH = 2'd2;

   localparam logic [1:0] CSR_FIRST_CODE   = 2'd0;
   localparam logic [1:0] CSR_LINE_ADVANCE = 2'd1;
   localparam logic [1:0] CSR_FONT_ASCENT  = 2'd2;

   localparam logic [7:0] FIRST_CODE_RESET   = 8'd32;
   localparam logic [7:0] LINE_ADVANCE_RESET = 8'd16;
   localparam logic [7:0] FONT_ASCENT_RESET  = 8'd12;

   localparam logic [7:0] NEWLINE_CODE = 8'd10;

   localparam logic signed [15:0] S16_MAX = 16'sh7fff;
   localparam logic signed [15:0] S16_MIN = -16'sh8000;

   typedef struct packed {
      logic signed [7:0] lo_x;
      logic signed [7:0] hi_x;
      logic signed [7:0] lo_y;
      logic signed [7:0] hi_y;
      logic [7:0]        adv;
   } metric_type;

   typedef struct packed {
      logic signed [15:0] value;
      logic               clipped;
   } sat_type;

   function automatic sat_type clip16(input logic signed [17:0] v);
      sat_type r;
      if (v > 18'sd32767) begin
         r.value   = S16_MAX;
         r.clipped = 1'b1;
      end else if (v < -18'sd32768) begin
         r.value   = S16_MIN;
         r.clipped = 1'b1;
      end else begin
         r.value   = v[15:0];
         r.clipped = 1'b0;
      end
      return r;
   endfunction

endpackage

// ===== hw/rtl/text_bounding_box_unit.sv =====
// text bounding box unit: glyph metrics memory, pen walk and bound tracking
// an accepted finish beat is registered in the execute stage, then raises rsp_valid
// throughput: one beat per cycle; all beats stall while a finish waits on an unread report
// reset: synchronous; csr registers return to reset values, pen, bounds and flags clear,
//   metrics memory contents stay undefined until loaded (no clearing pass)
module text_bounding_box_unit #(
   parameter int GLYPH_COUNT = tbb_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [6:0]         req_glyph_slot,
   input  logic [7:0]         req_char_code,
   input  logic signed [7:0]  req_glyph_left,
   input  logic signed [7:0]  req_glyph_right,
   input  logic signed [7:0]  req_glyph_bottom,
   input  logic signed [7:0]  req_glyph_top,
   input  logic [7:0]         req_glyph_advance,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic signed [15:0] rsp_box_left,
   output logic signed [15:0] rsp_box_top,
   output logic [15:0]        rsp_box_width,
   output logic [15:0]        rsp_box_height,
   output logic               rsp_no_glyph,
   output logic               rsp_saturated
);

   localparam int ADDR_W = (GLYPH_COUNT > 1) ? $clog2(GLYPH_COUNT) : 1;

   typedef enum logic [1:0] {
      OP_GLYPH,
      OP_NEWLINE,
      OP_FINISH
   } op_type;

   // configuration registers
   logic [7:0] first_code_ff, line_advance_ff, font_ascent_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         first_code_ff   <= tbb_pkg::FIRST_CODE_RESET;
         line_advance_ff <= tbb_pkg::LINE_ADVANCE_RESET;
         font_ascent_ff  <= tbb_pkg::FONT_ASCENT_RESET;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            tbb_pkg::CSR_FIRST_CODE:   first_code_ff   <= csr_write_data;
            tbb_pkg::CSR_LINE_ADVANCE: line_advance_ff <= csr_write_data;
            tbb_pkg::CSR_FONT_ASCENT:  font_ascent_ff  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // input decode
   logic              accept, stall;
   logic [8:0]        glyph_idx;
   logic              code_in_table, slot_ok, is_newline;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr, rd_addr;
   logic [7:0]        slot_w;
   tbb_pkg::metric_type wr_data;

   assign accept        = req_valid && req_ready;
   assign glyph_idx     = {1'b0, req_char_code} - {1'b0, first_code_ff};
   assign code_in_table = !glyph_idx[8] && (glyph_idx < 9'(GLYPH_COUNT));
   assign is_newline    = (req_char_code == tbb_pkg::NEWLINE_CODE);
   assign slot_w        = {1'b0, req_glyph_slot};
   assign slot_ok       = ({1'b0, slot_w} < 9'(GLYPH_COUNT));
   assign wr_en         = accept && (req_command == tbb_pkg::CMD_LOAD) && slot_ok;
   assign wr_addr       = slot_w[ADDR_W-1:0];
   assign rd_addr       = glyph_idx[ADDR_W-1:0];

   always_comb begin
      wr_data.lo_x = req_glyph_left;
      wr_data.hi_x = req_glyph_right;
      wr_data.lo_y = req_glyph_bottom;
      wr_data.hi_y = req_glyph_top;
      wr_data.adv  = req_glyph_advance;
   end

   // metrics memory
   tbb_pkg::metric_type metrics_mem [GLYPH_COUNT];
   tbb_pkg::metric_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         metrics_mem[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         rd_data_ff <= metrics_mem[rd_addr];
      end
   end

   // execute stage
   logic   s1_valid_ff, s1_valid_in;
   op_type s1_op_ff, s1_op_in;

   always_comb begin
      s1_valid_in = 1'b0;
      s1_op_in    = OP_FINISH;
      if (accept) begin
         priority if (req_command == tbb_pkg::CMD_FINISH) begin
            s1_valid_in = 1'b1;
            s1_op_in    = OP_FINISH;
         end else if (req_command == tbb_pkg::CMD_CHAR && is_newline) begin
            s1_valid_in = 1'b1;
            s1_op_in    = OP_NEWLINE;
         end else if (req_command == tbb_pkg::CMD_CHAR && code_in_table) begin
            s1_valid_in = 1'b1;
            s1_op_in    = OP_GLYPH;
         end else begin
            s1_valid_in = 1'b0;
         end
      end
   end

   assign stall     = s1_valid_ff && (s1_op_ff == OP_FINISH) && rsp_valid && !rsp_ready;
   assign req_ready = !stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (!stall) begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (!stall) begin
         s1_op_ff <= s1_op_in;
      end
   end

   // run state
   logic signed [15:0] pen_x_ff, pen_y_ff, pen_x_in, pen_y_in;
   logic signed [15:0] left_ff, right_ff, top_ff, bottom_ff;
   logic signed [15:0] left_in, right_in, top_in, bottom_in;
   logic               seen_ff, seen_in, clip_ff, clip_in;
   logic signed [17:0] base_w;
   tbb_pkg::sat_type   z_left, z_right, z_top, z_bottom, z_adv, z_line;
   logic               do_finish;

   assign base_w = 18'(pen_y_ff) + $signed({10'd0, font_ascent_ff});

   always_comb begin
      z_left   = tbb_pkg::clip16(18'(pen_x_ff) + 18'(rd_data_ff.lo_x));
      z_right  = tbb_pkg::clip16(18'(pen_x_ff) + 18'(rd_data_ff.hi_x));
      z_top    = tbb_pkg::clip16(base_w - 18'(rd_data_ff.hi_y));
      z_bottom = tbb_pkg::clip16(base_w - 18'(rd_data_ff.lo_y));
      z_adv    = tbb_pkg::clip16(18'(pen_x_ff) + $signed({10'd0, rd_data_ff.adv}));
      z_line   = tbb_pkg::clip16(18'(pen_y_ff) + $signed({10'd0, line_advance_ff}));
   end

   assign do_finish = s1_valid_ff && !stall && (s1_op_ff == OP_FINISH);

   always_comb begin
      pen_x_in  = pen_x_ff;
      pen_y_in  = pen_y_ff;
      left_in   = left_ff;
      right_in  = right_ff;
      top_in    = top_ff;
      bottom_in = bottom_ff;
      seen_in   = seen_ff;
      clip_in   = clip_ff;
      if (s1_valid_ff && !stall) begin
         unique case (s1_op_ff)
            OP_GLYPH: begin
               if (z_left.value < left_ff) left_in = z_left.value;
               if (z_right.value > right_ff) right_in = z_right.value;
               if (z_top.value < top_ff) top_in = z_top.value;
               if (z_bottom.value > bottom_ff) bottom_in = z_bottom.value;
               pen_x_in = z_adv.value;
               seen_in  = 1'b1;
               clip_in  = clip_ff | z_left.clipped | z_right.clipped | z_top.clipped
                          | z_bottom.clipped | z_adv.clipped;
            end
            OP_NEWLINE: begin
               pen_x_in = '0;
               pen_y_in = z_line.value;
               clip_in  = clip_ff | z_line.clipped;
            end
            OP_FINISH: begin
               pen_x_in  = '0;
               pen_y_in  = '0;
               left_in   = tbb_pkg::S16_MAX;
               right_in  = tbb_pkg::S16_MIN;
               top_in    = tbb_pkg::S16_MAX;
               bottom_in = tbb_pkg::S16_MIN;
               seen_in   = 1'b0;
               clip_in   = 1'b0;
            end
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_x_ff  <= '0;
         pen_y_ff  <= '0;
         left_ff   <= tbb_pkg::S16_MAX;
         right_ff  <= tbb_pkg::S16_MIN;
         top_ff    <= tbb_pkg::S16_MAX;
         bottom_ff <= tbb_pkg::S16_MIN;
         seen_ff   <= 1'b0;
         clip_ff   <= 1'b0;
      end else begin
         pen_x_ff  <= pen_x_in;
         pen_y_ff  <= pen_y_in;
         left_ff   <= left_in;
         right_ff  <= right_in;
         top_ff    <= top_in;
         bottom_ff <= bottom_in;
         seen_ff   <= seen_in;
         clip_ff   <= clip_in;
      end
   end

   // result register
   logic               rsp_valid_ff;
   logic signed [15:0] box_left_ff, box_top_ff;
   logic [15:0]        box_width_ff, box_height_ff;
   logic               no_glyph_ff, saturated_ff;
   logic signed [16:0] width_w, height_w;

   assign width_w  = 17'(right_ff) - 17'(left_ff);
   assign height_w = 17'(bottom_ff) - 17'(top_ff);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (do_finish) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (do_finish) begin
         saturated_ff <= clip_ff;
         no_glyph_ff  <= !seen_ff;
         if (seen_ff) begin
            box_left_ff   <= left_ff;
            box_top_ff    <= top_ff;
            box_width_ff  <= width_w[16] ? 16'd0 : width_w[15:0];
            box_height_ff <= height_w[16] ? 16'd0 : height_w[15:0];
         end else begin
            box_left_ff   <= '0;
            box_top_ff    <= '0;
            box_width_ff  <= '0;
            box_height_ff <= '0;
         end
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_box_left   = box_left_ff;
   assign rsp_box_top    = box_top_ff;
   assign rsp_box_width  = box_width_ff;
   assign rsp_box_height = box_height_ff;
   assign rsp_no_glyph   = no_glyph_ff;
   assign rsp_saturated  = saturated_ff;

endmodule

// ===== tb/tbb_box_checker.sv =====
// scoreboard for the text bounding box unit: pen and bound prediction, box report compare
module tbb_box_checker #(
   parameter int GLYPH_COUNT = tbb_pkg::GLYPH_COUNT_DEFAULT
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               csr_write_enable,
   input  logic [1:0]         csr_index,
   input  logic [7:0]         csr_write_data,
   input  logic               req_valid,
   input  logic               req_ready,
   input  logic [1:0]         req_command,
   input  logic [6:0]         req_glyph_slot,
   input  logic [7:0]         req_char_code,
   input  logic signed [7:0]  req_glyph_left,
   input  logic signed [7:0]  req_glyph_right,
   input  logic signed [7:0]  req_glyph_bottom,
   input  logic signed [7:0]  req_glyph_top,
   input  logic [7:0]         req_glyph_advance,
   input  logic               rsp_valid,
   input  logic               rsp_ready,
   input  logic signed [15:0] rsp_box_left,
   input  logic signed [15:0] rsp_box_top,
   input  logic [15:0]        rsp_box_width,
   input  logic [15:0]        rsp_box_height,
   input  logic               rsp_no_glyph,
   input  logic               rsp_saturated,
   output int                 error_count,
   output int                 open_count
);

   typedef struct packed {
      logic signed [15:0] left;
      logic signed [15:0] top;
      logic [15:0]        width;
      logic [15:0]        height;
      logic               no_glyph;
      logic               saturated;
   } box_report_type;

   box_report_type      expected_boxes[$];
   tbb_pkg::metric_type glyph_metrics[GLYPH_COUNT];
   int                  pen_x, pen_y;
   int                  left_edge, right_edge, top_edge, bottom_edge;
   bit                  seen_glyph, clipped;
   logic [7:0]          first_code, line_advance, font_ascent;
   int                  mismatches = 0;

   function automatic int saturate16(input int v);
      if (v > 32767) begin
         clipped = 1'b1;
         return 32767;
      end
      if (v < -32768) begin
         clipped = 1'b1;
         return -32768;
      end
      return v;
   endfunction

   function automatic void restart_layout();
      pen_x       = 0;
      pen_y       = 0;
      left_edge   = 32767;
      right_edge  = -32768;
      top_edge    = 32767;
      bottom_edge = -32768;
      seen_glyph  = 1'b0;
      clipped     = 1'b0;
   endfunction

   function automatic void advance_layout(input logic [1:0] cmd, input logic [6:0] slot,
                                          input logic [7:0] code,
                                          input tbb_pkg::metric_type loaded);
      int                  index;
      int                  base;
      int                  cand;
      int                  span;
      tbb_pkg::metric_type m;
      box_report_type      box;
      case (cmd)
         tbb_pkg::CMD_LOAD: begin
            if (slot < GLYPH_COUNT) glyph_metrics[slot] = loaded;
         end
         tbb_pkg::CMD_CHAR: begin
            index = int'(code) - int'(first_code);
            if (code == tbb_pkg::NEWLINE_CODE) begin
               pen_y = saturate16(pen_y + int'(line_advance));
               pen_x = 0;
            end else if (index >= 0 && index < GLYPH_COUNT) begin
               m    = glyph_metrics[index];
               base = pen_y + int'(font_ascent);
               cand = saturate16(pen_x + int'(m.lo_x));
               if (cand < left_edge) left_edge = cand;
               cand = saturate16(base - int'(m.hi_y));
               if (cand < top_edge) top_edge = cand;
               cand = saturate16(pen_x + int'(m.hi_x));
               if (cand > right_edge) right_edge = cand;
               cand = saturate16(base - int'(m.lo_y));
               if (cand > bottom_edge) bottom_edge = cand;
               seen_glyph = 1'b1;
               pen_x = saturate16(pen_x + int'(m.adv));
            end
         end
         tbb_pkg::CMD_FINISH: begin
            box = '0;
            if (seen_glyph) begin
               box.left   = left_edge[15:0];
               box.top    = top_edge[15:0];
               span       = right_edge - left_edge;
               box.width  = (span < 0) ? 16'd0 : span[15:0];
               span       = bottom_edge - top_edge;
               box.height = (span < 0) ? 16'd0 : span[15:0];
            end else begin
               box.no_glyph = 1'b1;
            end
            box.saturated = clipped;
            expected_boxes.push_back(box);
            restart_layout();
         end
         default: ;
      endcase
   endfunction

   function automatic void report_field(input string name, input logic signed [31:0] want,
                                        input logic signed [31:0] got);
      if (want !== got) begin
         mismatches++;
         $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      end
   endfunction

   always @(posedge clock) begin : track
      box_report_type want;
      if (reset) begin
         expected_boxes.delete();
         first_code   = tbb_pkg::FIRST_CODE_RESET;
         line_advance = tbb_pkg::LINE_ADVANCE_RESET;
         font_ascent  = tbb_pkg::FONT_ASCENT_RESET;
         restart_layout();
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_boxes.size() == 0) begin
               mismatches++;
               $display("%0t: expected no box report, got left %0d top %0d w %0d h %0d",
                        $time, rsp_box_left, rsp_box_top, rsp_box_width, rsp_box_height);
            end else begin
               want = expected_boxes.pop_front();
               report_field("box_left", want.left, rsp_box_left);
               report_field("box_top", want.top, rsp_box_top);
               report_field("box_width", want.width, rsp_box_width);
               report_field("box_height", want.height, rsp_box_height);
               report_field("no_glyph", want.no_glyph, rsp_no_glyph);
               report_field("saturated", want.saturated, rsp_saturated);
            end
         end
         if (csr_write_enable) begin
            case (csr_index)
               tbb_pkg::CSR_FIRST_CODE:   first_code   = csr_write_data;
               tbb_pkg::CSR_LINE_ADVANCE: line_advance = csr_write_data;
               tbb_pkg::CSR_FONT_ASCENT:  font_ascent  = csr_write_data;
               default: ;
            endcase
         end
         if (req_valid && req_ready) begin
            advance_layout(req_command, req_glyph_slot, req_char_code,
                           {req_glyph_left, req_glyph_right, req_glyph_bottom,
                            req_glyph_top, req_glyph_advance});
         end
      end
      error_count <= mismatches;
      open_count  <= expected_boxes.size();
   end

endmodule

// ===== tb/tb.sv =====
// testbench top for the text bounding box unit: clock, reset, stimulus and verdict
module tb;

   localparam int         GLYPH_SLOTS    = tbb_pkg::GLYPH_COUNT_DEFAULT;
   localparam int         WATCHDOG_LIMIT = 2000;
   localparam logic [1:0] CMD_UNUSED     = 2'd3;

   logic               clock = 1'b0;
   logic               reset = 1'b1;
   logic               csr_write_enable = 1'b0;
   logic [1:0]         csr_index = tbb_pkg::CSR_FIRST_CODE;
   logic [7:0]         csr_write_data = '0;
   logic               req_valid = 1'b0;
   logic               req_ready;
   logic [1:0]         req_command = tbb_pkg::CMD_LOAD;
   logic [6:0]         req_glyph_slot = '0;
   logic [7:0]         req_char_code = '0;
   logic signed [7:0]  req_glyph_left = '0;
   logic signed [7:0]  req_glyph_right = '0;
   logic signed [7:0]  req_glyph_bottom = '0;
   logic signed [7:0]  req_glyph_top = '0;
   logic [7:0]         req_glyph_advance = '0;
   logic               rsp_valid;
   logic               rsp_ready = 1'b0;
   logic signed [15:0] rsp_box_left;
   logic signed [15:0] rsp_box_top;
   logic [15:0]        rsp_box_width;
   logic [15:0]        rsp_box_height;
   logic               rsp_no_glyph;
   logic               rsp_saturated;
   int                 error_count;
   int                 open_count;

   int         sent = 0;
   bit         calm = 1'b0;
   int         quiet_cycles = 0;
   bit         loaded_slots[GLYPH_SLOTS];
   logic [7:0] first_code_now = tbb_pkg::FIRST_CODE_RESET;

   text_bounding_box_unit dut (.*);

   tbb_box_checker box_checker (.*);

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   always @(negedge clock) rsp_ready <= calm || ($urandom_range(99) >= 19);

   // no csr write and no beat on the request or response channel for too long means a hang
   always @(posedge clock) begin
      if (reset || csr_write_enable || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("DONE: errors detected");
            $finish;
         end
      end
   end

   function automatic tbb_pkg::metric_type random_shape();
      return tbb_pkg::metric_type'({$urandom(), 8'($urandom())});
   endfunction

   function automatic logic [7:0] glyph_code();
      int c;
      c = int'(first_code_now) + int'($urandom_range(127));
      if (c > 255 || $urandom_range(3) == 0) c = $urandom_range(255);
      return 8'(c);
   endfunction

   task automatic send_beat(input logic [1:0] cmd, input logic [6:0] slot,
                            input logic [7:0] code, input tbb_pkg::metric_type shape);
      while (!calm && $urandom_range(99) < 19) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid         <= 1'b1;
      req_command       <= cmd;
      req_glyph_slot    <= slot;
      req_char_code     <= code;
      req_glyph_left    <= shape.lo_x;
      req_glyph_right   <= shape.hi_x;
      req_glyph_bottom  <= shape.lo_y;
      req_glyph_top     <= shape.hi_y;
      req_glyph_advance <= shape.adv;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      if (cmd == tbb_pkg::CMD_LOAD) loaded_slots[slot] = 1'b1;
      if (cmd == tbb_pkg::CMD_LOAD || cmd == tbb_pkg::CMD_CHAR || cmd == tbb_pkg::CMD_FINISH)
         sent++;
      calm = (sent >= 400 && sent < 560);
      @(negedge clock);
   endtask

   // a glyph code whose table entry is still empty gets its metrics loaded first
   task automatic send_char(input logic [7:0] code);
      int index;
      index = int'(code) - int'(first_code_now);
      if (code != tbb_pkg::NEWLINE_CODE && index >= 0 && index < GLYPH_SLOTS
          && !loaded_slots[index])
         send_beat(tbb_pkg::CMD_LOAD, 7'(index), 8'($urandom()), random_shape());
      send_beat(tbb_pkg::CMD_CHAR, 7'($urandom()), code, random_shape());
   endtask

   task automatic send_finish();
      send_beat(tbb_pkg::CMD_FINISH, 7'($urandom()), 8'($urandom()), random_shape());
   endtask

   task automatic configure(input logic [7:0] first_code, input logic [7:0] line_step,
                            input logic [7:0] ascent);
      req_valid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (4) @(negedge clock);
      csr_write_enable <= 1'b1;
      csr_index        <= tbb_pkg::CSR_FIRST_CODE;
      csr_write_data   <= first_code;
      @(negedge clock);
      csr_index        <= tbb_pkg::CSR_LINE_ADVANCE;
      csr_write_data   <= line_step;
      @(negedge clock);
      csr_index        <= tbb_pkg::CSR_FONT_ASCENT;
      csr_write_data   <= ascent;
      @(negedge clock);
      csr_write_enable <= 1'b0;
      first_code_now = first_code;
   endtask

   task automatic run_phase(input int budget);
      int                  stop_at;
      int                  pick;
      int                  length;
      bit                  tall;
      bit                  wide;
      logic [1:0]          cmd;
      logic [7:0]          code;
      tbb_pkg::metric_type shape;
      stop_at = sent + budget;
      while (sent < stop_at) begin
         pick = $urandom_range(99);
         if (pick < 10) begin
            cmd  = 2'($urandom_range(3));
            code = 8'($urandom());
            if (cmd == tbb_pkg::CMD_CHAR) send_char(code);
            else send_beat(cmd, 7'($urandom()), code, random_shape());
         end else if (pick < 25) begin
            repeat ($urandom_range(1, 6))
               send_beat(tbb_pkg::CMD_LOAD, 7'($urandom()), 8'($urandom()), random_shape());
         end else begin
            pick = $urandom_range(99);
            tall = 1'b0;
            wide = 1'b0;
            if (pick < 8) begin
               // long line runs drive the pen into saturation
               length = $urandom_range(150, 250);
               tall   = $urandom_range(1);
               wide   = !tall;
               if (wide) begin
                  shape     = random_shape();
                  shape.adv = 8'hff;
                  send_beat(tbb_pkg::CMD_LOAD, 7'd0, 8'($urandom()), shape);
               end
            end else if (pick < 18) begin
               length = $urandom_range(13, 40);
            end else begin
               length = $urandom_range(1, 12);
            end
            repeat (length) begin
               pick = $urandom_range(99);
               if (tall) code = (pick < 70) ? tbb_pkg::NEWLINE_CODE : glyph_code();
               else if (wide) code = (pick < 70) ? first_code_now : glyph_code();
               else code = (pick < 8) ? tbb_pkg::NEWLINE_CODE : glyph_code();
               send_char(code);
            end
            send_finish();
         end
      end
   endtask

   initial begin
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      configure(tbb_pkg::FIRST_CODE_RESET, tbb_pkg::LINE_ADVANCE_RESET,
                tbb_pkg::FONT_ASCENT_RESET);

      // empty string, then widest and inverted glyph boxes
      send_finish();
      send_beat(tbb_pkg::CMD_LOAD, 7'd0, 8'($urandom()),
                '{lo_x: 8'h80, hi_x: 8'h7f, lo_y: 8'h80, hi_y: 8'h7f, adv: 8'hff});
      send_beat(tbb_pkg::CMD_LOAD, 7'd127, 8'($urandom()),
                '{lo_x: 8'h7f, hi_x: 8'h80, lo_y: 8'h7f, hi_y: 8'h80, adv: 8'h00});
      send_beat(tbb_pkg::CMD_LOAD, 7'd1, 8'($urandom()), '0);
      send_char(8'd32);
      send_char(tbb_pkg::NEWLINE_CODE);
      send_char(8'd159);
      send_char(8'd31);
      send_char(8'd160);
      send_beat(CMD_UNUSED, 7'($urandom()), 8'($urandom()), random_shape());
      send_finish();
      send_char(8'd159);
      send_finish();
      send_char(8'd33);
      send_finish();

      // code zero inside the table and newline inside the table range
      configure(8'd0, 8'd255, 8'd255);
      send_char(8'd0);
      send_char(tbb_pkg::NEWLINE_CODE);
      send_char(8'd127);
      send_char(8'd128);
      send_finish();

      configure(8'd255, 8'd0, 8'd0);
      send_char(8'd255);
      send_char(tbb_pkg::NEWLINE_CODE);
      send_char(8'd254);
      send_finish();
      send_finish();

      configure(tbb_pkg::FIRST_CODE_RESET, tbb_pkg::LINE_ADVANCE_RESET,
                tbb_pkg::FONT_ASCENT_RESET);
      run_phase(155);
      configure(8'd0, 8'd255, 8'd255);
      run_phase(155);
      configure(8'd255, 8'd0, 8'd0);
      run_phase(155);
      repeat (3) begin
         configure(8'($urandom()), 8'($urandom()), 8'($urandom()));
         run_phase(155);
      end

      req_valid <= 1'b0;
      while (open_count != 0) @(negedge clock);
      repeat (10) @(negedge clock);
      if (error_count == 0) $display("DONE: 0 errors");
      else $display("DONE: errors detected");
      $finish;
   end

endmodule
